// File: rtl/spira_pkg.sv
// Shared types and constants for the SPI register-access master.
package spira_pkg;

  // Default serial frame width in bits
  localparam int unsigned SPIRA_FRAME_BITS = 16;

  // Field widths of one tick item and one result item
  localparam int unsigned ADDR_W      = 4;
  localparam int unsigned WDATA_W     = 11;
  localparam int unsigned HALF_W      = 16;
  localparam int unsigned RDATA_W     = 16;
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 24;

  // Command word layout: read flag in bit 15, address in bits 14..11
  localparam logic [15:0] READ_FLAG = 16'h8000;

  // Link phase
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HIGH = 2'd1,
    PH_LOW  = 2'd2,
    PH_GAP  = 2'd3
  } phase_e;

  // One tick item
  typedef struct packed {
    logic               start_req;
    logic               mode;       // 0 read, 1 write
    logic [ADDR_W-1:0]  reg_addr;
    logic [WDATA_W-1:0] write_data;
    logic               miso;
  } item_t;

  // One result item: line levels after the tick plus status
  typedef struct packed {
    logic               sclk;
    logic               mosi;
    logic               cs_n;
    logic               busy;
    logic               done;
    logic [RDATA_W-1:0] rd_word;
  } res_t;

endpackage

// File: rtl/spira_engine.sv
// Per-tick SPI link state machine: frame shifting, SCLK timing and capture.
module spira_engine #(
  parameter int unsigned FRAME_BITS = spira_pkg::SPIRA_FRAME_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              step_i,
  input  spira_pkg::item_t                  item_i,
  input  logic                              cfg_we_i,
  input  logic [spira_pkg::HALF_W-1:0]      cfg_half_i,
  output spira_pkg::res_t                   res_o
);
  import spira_pkg::*;

  localparam int unsigned BW = $clog2(FRAME_BITS);
  localparam logic [BW-1:0] LAST_BIT = BW'(FRAME_BITS - 1);

  phase_e                phase_q, phase_d;
  logic [BW-1:0]         bit_q, bit_d;
  logic [FRAME_BITS-1:0] tx_q, tx_d;
  logic [FRAME_BITS-1:0] rx_q, rx_d;
  logic                  second_q, second_d;
  logic                  wr_q, wr_d;
  logic [HALF_W-1:0]     tick_q, tick_d;
  logic [HALF_W-1:0]     half_q;

  logic [HALF_W-1:0]     half_eff;
  logic                  half_done;
  logic [BW-1:0]         pos_now, pos_next;
  logic [FRAME_BITS-1:0] rx_cap;
  logic [15:0]           cmd_word;
  logic [31:0]           cmd_wide;
  logic [31:0]           rx_wide;
  logic                  done;
  logic [RDATA_W-1:0]    rd;

  // Half-period end: zero acts as one
  assign half_eff  = (half_q == '0) ? HALF_W'(1) : half_q;
  assign half_done = ({1'b0, tick_q} + (HALF_W+1)'(1)) >= {1'b0, half_eff};

  // Bit position on the wire, MSB first
  assign pos_now  = LAST_BIT - bit_q;
  assign pos_next = LAST_BIT - bit_d;

  // Capture MISO on the first tick after the falling edge
  assign rx_cap = rx_q | ((item_i.miso && tick_q == '0) ?
                          (FRAME_BITS'(1) << pos_now) : '0);
  assign rx_wide = 32'(rx_cap);

  // First command word of an access
  assign cmd_word = item_i.mode ?
                    {1'b0, item_i.reg_addr, item_i.write_data} :
                    (READ_FLAG | {1'b0, item_i.reg_addr, WDATA_W'(0)});
  assign cmd_wide = {16'b0, cmd_word};

  // Next-state logic
  always_comb begin
    phase_d  = phase_q;
    bit_d    = bit_q;
    tx_d     = tx_q;
    rx_d     = rx_q;
    second_d = second_q;
    wr_d     = wr_q;
    tick_d   = tick_q;
    done     = 1'b0;
    rd       = '0;
    unique case (phase_q)
      PH_HIGH: begin
        if (half_done) begin
          phase_d = PH_LOW;
          tick_d  = '0;
        end else begin
          tick_d = tick_q + HALF_W'(1);
        end
      end
      PH_LOW: begin
        rx_d = rx_cap;
        if (half_done) begin
          tick_d = '0;
          if (bit_q == LAST_BIT) begin
            if (!wr_q && !second_q) begin
              second_d = 1'b1;
              tx_d     = '1;
              phase_d  = PH_GAP;
            end else begin
              if (!wr_q) begin
                rd = rx_wide[RDATA_W-1:0];
              end
              done    = 1'b1;
              phase_d = PH_IDLE;
            end
          end else begin
            bit_d   = bit_q + BW'(1);
            phase_d = PH_HIGH;
          end
        end else begin
          tick_d = tick_q + HALF_W'(1);
        end
      end
      PH_GAP: begin
        if (half_done) begin
          bit_d   = '0;
          rx_d    = '0;
          tick_d  = '0;
          phase_d = PH_HIGH;
        end else begin
          tick_d = tick_q + HALF_W'(1);
        end
      end
      PH_IDLE: begin
        if (item_i.start_req) begin
          wr_d     = item_i.mode;
          second_d = 1'b0;
          tx_d     = cmd_wide[FRAME_BITS-1:0];
          rx_d     = '0;
          bit_d    = '0;
          tick_d   = '0;
          phase_d  = PH_HIGH;
        end
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  // Result for this tick, from the state after it
  always_comb begin
    res_o.sclk    = (phase_d == PH_HIGH);
    res_o.cs_n    = (phase_d == PH_IDLE) || (phase_d == PH_GAP);
    res_o.mosi    = res_o.cs_n ? 1'b0 : tx_d[pos_next];
    res_o.busy    = (phase_d != PH_IDLE);
    res_o.done    = done;
    res_o.rd_word = rd;
  end

  // State registers advance once per accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      bit_q    <= '0;
      tx_q     <= '0;
      rx_q     <= '0;
      second_q <= 1'b0;
      wr_q     <= 1'b0;
      tick_q   <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      bit_q    <= bit_d;
      tx_q     <= tx_d;
      rx_q     <= rx_d;
      second_q <= second_d;
      wr_q     <= wr_d;
      tick_q   <= tick_d;
    end
  end

  // Half-period register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= HALF_W'(1);
    end else if (cfg_we_i) begin
      half_q <= cfg_half_i;
    end
  end

endmodule

// File: rtl/spi_register_access_master_unit.sv
// Top level of the SPI register-access master: stream ports and result register.
//
// Each input transfer is one tick of the serial link and yields exactly one
// result transfer with the SCLK, MOSI and CS_N levels after that tick plus
// busy/done status and, on the done tick of a read, the word captured in the
// second frame. The state machine updates in one step per tick and a single
// output register holds the result, so one tick is accepted every clock cycle
// while that register is empty or being drained in the same cycle, and each
// result is registered in the cycle after its tick. A write access lasts
// 2*FRAME_BITS half periods, a read 4*FRAME_BITS+1, with the half period set by
// the configuration register in ticks (0 counts as 1). The user must write the
// configuration register only while no access is in progress (not enforced).
module spi_register_access_master_unit #(
  parameter int unsigned FRAME_BITS = spira_pkg::SPIRA_FRAME_BITS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // start_req[0], reg_addr[4:1], write_data[15:5], miso[16], zero pad
  input  logic [spira_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  // mode[0]
  input  logic                               s_axis_tuser_i,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // sclk[0], mosi[1], cs_n[2], busy_res[3], done_res[4], rd_word[20:5], pad
  output logic [spira_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  input  logic [spira_pkg::HALF_W-1:0]       cfg_data_i,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o
);
  import spira_pkg::*;

  item_t item;
  res_t  res;
  logic  in_xfer;
  logic  out_valid_q, out_valid_d;
  res_t  out_res_q;

  // Unpack the tick item
  assign item.start_req  = s_axis_tdata_i[0];
  assign item.mode       = s_axis_tuser_i;
  assign item.reg_addr   = s_axis_tdata_i[4:1];
  assign item.write_data = s_axis_tdata_i[15:5];
  assign item.miso       = s_axis_tdata_i[16];

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  spira_engine #(
    .FRAME_BITS(FRAME_BITS)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (in_xfer),
    .item_i     (item),
    .cfg_we_i   (cfg_valid_i),
    .cfg_half_i (cfg_data_i),
    .res_o      (res)
  );

  // Result register occupancy
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_xfer) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b0, out_res_q.rd_word, out_res_q.done, out_res_q.busy,
                            out_res_q.cs_n, out_res_q.mosi, out_res_q.sclk};

endmodule

// File: rtl/spira_checker.sv
// Port-level checks for the SPI register-access master, bound to the top level.
module spira_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic [spira_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o,
  input logic                               m_axis_tvalid_o,
  input logic                               m_axis_tready_i
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  // Done ends the access: link idle with chip select high
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[4] |-> !m_axis_tdata_o[3] && m_axis_tdata_o[2])
    else $error("done while link still active");

  // MOSI is quiet and SCLK low while chip select is high
  a_cs_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[2] |-> !m_axis_tdata_o[1] && !m_axis_tdata_o[0])
    else $error("line activity with chip select high");

  // Read data only shows with done
  a_rdata_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[4] |-> m_axis_tdata_o[20:5] == '0)
    else $error("read data without done");

endmodule

bind spi_register_access_master_unit spira_checker u_spira_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i)
);
